// File: design/swgt_pkg.sv
// Shared types and constants for the sine wave gray texel generator.
package swgt_pkg;

	localparam int COORD_W  = 13;
	localparam int DIR_W    = 16;
	localparam int FREQ_W   = 24;
	localparam int OFFS_W   = 16;
	localparam int GRAY_W   = 8;
	localparam int PROD_W   = DIR_W + COORD_W + 1;   // signed dir times unsigned coord
	localparam int DOT_W    = PROD_W + 1;
	localparam int FRAC_W   = 38;                    // turn fraction, 14 + 24 bits
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;

	localparam longint unsigned ONE_Q30    = 64'd1073741824;
	localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

	typedef logic        [COORD_W-1:0] coord_t;
	typedef logic signed [DIR_W-1:0]   dir_t;
	typedef logic        [FREQ_W-1:0]  freq_t;
	typedef logic        [OFFS_W-1:0]  offs_t;
	typedef logic signed [DOT_W-1:0]   dot_t;
	typedef logic        [GRAY_W-1:0]  gray_t;

	typedef enum logic [1:0] {
		REG_DIR_X        = 2'd0,
		REG_DIR_Y        = 2'd1,
		REG_SPATIAL_FREQ = 2'd2,
		REG_PHASE_OFFSET = 2'd3
	} reg_idx_t;

endpackage

// File: design/sine_wave_gray_texel.sv
// Top level: directional sine wave gray texel generator with APB registers.
//
//   channel | signals                              | word
//   --------+--------------------------------------+------------------------
//   input   | in_valid, in_ready                   | x_coord, y_coord
//   output  | out_valid, out_ready                 | gray
//   config  | psel, penable, pwrite, paddr, pready | pwdata in, prdata out
//
// Six register stages: two multipliers, dot sum, phase multiply, offset add,
// quadrant fold, table lookup. One word enters per clock while the output
// does not stall; the 31x24 phase multiply and the table read each take a
// stage. Ready ripples back stage by stage, so bubbles close up and a stall
// at the output holds a word once the stages ahead are full. Reset clears
// valid bits and the four registers to zero; table contents are constants.
module sine_wave_gray_texel #(
	parameter int PHASE_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB-style register port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [swgt_pkg::APB_AW-1:0]     paddr,
	input  logic [swgt_pkg::APB_DW-1:0]     pwdata,
	output logic [swgt_pkg::APB_DW-1:0]     prdata,
	output logic                            pready,
	// pixel coordinate words
	input  logic                            in_valid,
	output logic                            in_ready,
	input  swgt_pkg::coord_t                x_coord,
	input  swgt_pkg::coord_t                y_coord,
	// gray words
	output logic                            out_valid,
	input  logic                            out_ready,
	output swgt_pkg::gray_t                 gray
);

	swgt_pkg::dir_t      dir_x_q, dir_y_q;
	swgt_pkg::freq_t     spatial_freq_q;
	swgt_pkg::offs_t     phase_offset_q;
	swgt_pkg::reg_idx_t  reg_idx;
	logic                wr_en;

	logic                dot_valid, dot_ready;
	swgt_pkg::dot_t      dot;
	logic                ph_valid, ph_ready;
	logic [PHASE_BITS-1:0] addr;

	// ---------------- register file ----------------
	// word address decode; byte offset bits are ignored
	assign reg_idx = swgt_pkg::reg_idx_t'(paddr[swgt_pkg::APB_AW-1:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_x_q        <= '0;
			dir_y_q        <= '0;
			spatial_freq_q <= '0;
			phase_offset_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				swgt_pkg::REG_DIR_X:        dir_x_q        <= pwdata[swgt_pkg::DIR_W-1:0];
				swgt_pkg::REG_DIR_Y:        dir_y_q        <= pwdata[swgt_pkg::DIR_W-1:0];
				swgt_pkg::REG_SPATIAL_FREQ: spatial_freq_q <= pwdata[swgt_pkg::FREQ_W-1:0];
				swgt_pkg::REG_PHASE_OFFSET: phase_offset_q <= pwdata[swgt_pkg::OFFS_W-1:0];
				default: ;
			endcase
		end
	end

	// read-back returns raw register bits, zero-extended
	always_comb begin
		unique case (reg_idx)
			swgt_pkg::REG_DIR_X:        prdata = swgt_pkg::APB_DW'(unsigned'(dir_x_q));
			swgt_pkg::REG_DIR_Y:        prdata = swgt_pkg::APB_DW'(unsigned'(dir_y_q));
			swgt_pkg::REG_SPATIAL_FREQ: prdata = swgt_pkg::APB_DW'(spatial_freq_q);
			swgt_pkg::REG_PHASE_OFFSET: prdata = swgt_pkg::APB_DW'(phase_offset_q);
			default:                    prdata = '0;
		endcase
	end

	// ---------------- datapath ----------------
	// stages 1-2: dir_x*x + dir_y*y, exact, 14 fraction bits
	swgt_dot u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.dir_x     (dir_x_q),
		.dir_y     (dir_y_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.out_valid (dot_valid),
		.out_ready (dot_ready),
		.dot       (dot)
	);

	// stages 3-4: turn fraction, 38 bits, truncated to the table address
	swgt_phase #(
		.PHASE_BITS (PHASE_BITS)
	) u_phase (
		.clk          (clk),
		.arst_n       (arst_n),
		.spatial_freq (spatial_freq_q),
		.phase_offset (phase_offset_q),
		.in_valid     (dot_valid),
		.in_ready     (dot_ready),
		.dot          (dot),
		.out_valid    (ph_valid),
		.out_ready    (ph_ready),
		.addr         (addr)
	);

	// stages 5-6: quarter-wave fold and gray lookup; stage 6 is the output register
	swgt_shade #(
		.PHASE_BITS (PHASE_BITS)
	) u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ph_valid),
		.in_ready  (ph_ready),
		.addr      (addr),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.gray      (gray)
	);

endmodule

// File: design/swgt_dot.sv
// Two-stage direction dot position: products, then sum.
module swgt_dot (
	input  logic               clk,
	input  logic               arst_n,
	input  swgt_pkg::dir_t     dir_x,
	input  swgt_pkg::dir_t     dir_y,
	input  logic               in_valid,
	output logic               in_ready,
	input  swgt_pkg::coord_t   x_coord,
	input  swgt_pkg::coord_t   y_coord,
	output logic               out_valid,
	input  logic               out_ready,
	output swgt_pkg::dot_t     dot
);

	logic                                   v_s1, v_s2;
	logic                                   rdy_s1, rdy_s2;
	logic signed [swgt_pkg::PROD_W-1:0]     px_s1, py_s1;
	swgt_pkg::dot_t                         dot_s2;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			px_s1 <= swgt_pkg::PROD_W'(dir_x * $signed({1'b0, x_coord}));
			py_s1 <= swgt_pkg::PROD_W'(dir_y * $signed({1'b0, y_coord}));
		end
		if (rdy_s2 && v_s1)
			dot_s2 <= swgt_pkg::DOT_W'(px_s1) + swgt_pkg::DOT_W'(py_s1);
	end

	assign out_valid = v_s2;
	assign dot       = dot_s2;

endmodule

// File: design/swgt_phase.sv
// Two-stage phase: scale by spatial frequency, add offset, take table address.
module swgt_phase #(
	parameter int PHASE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  swgt_pkg::freq_t        spatial_freq,
	input  swgt_pkg::offs_t        phase_offset,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  swgt_pkg::dot_t         dot,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [PHASE_BITS-1:0]  addr
);

	localparam int MUL_W = swgt_pkg::DOT_W + swgt_pkg::FREQ_W + 1;

	logic                           v_s3, v_s4;
	logic                           rdy_s3, rdy_s4;
	logic [swgt_pkg::FRAC_W-1:0]    ph_s3;
	logic signed [MUL_W-1:0]        prod;
	logic [swgt_pkg::FRAC_W-1:0]    ph_sum;
	logic [PHASE_BITS-1:0]          addr_s4;

	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	// low bits of the signed product are the turn fraction; wrap is free
	assign prod   = MUL_W'(dot * $signed({1'b0, spatial_freq}));
	assign ph_sum = ph_s3 + {phase_offset, (swgt_pkg::FRAC_W - swgt_pkg::OFFS_W)'(0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s3) v_s3 <= in_valid;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid)
			ph_s3 <= prod[swgt_pkg::FRAC_W-1:0];
		if (rdy_s4 && v_s3)
			addr_s4 <= ph_sum[swgt_pkg::FRAC_W-1 -: PHASE_BITS];
	end

	assign out_valid = v_s4;
	assign addr      = addr_s4;

endmodule

// File: design/swgt_shade.sv
// Two-stage shading: quarter-wave fold, then gray lookup from constant tables.
module swgt_shade #(
	parameter int PHASE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [PHASE_BITS-1:0]  addr,
	output logic                   out_valid,
	input  logic                   out_ready,
	output swgt_pkg::gray_t        gray
);

	localparam int QUARTER = 2 ** (PHASE_BITS - 2);
	localparam int IW      = PHASE_BITS - 1;            // holds 0..QUARTER
	localparam int LUT_N   = QUARTER + 1;
	localparam int GW      = swgt_pkg::GRAY_W;
	localparam logic [IW-1:0] QUARTER_I = IW'(QUARTER);

	// gray per folded index; neg selects the lower half turn
	function automatic logic [LUT_N*GW-1:0] build_lut(input logic neg);
		logic [LUT_N*GW-1:0] lut;
		longint unsigned     x, x2, t, g;
		longint              s;
		lut = '0;
		for (int r = 0; r < LUT_N; r++) begin
			x  = (longint'(r) * swgt_pkg::TWO_PI_Q30) >> PHASE_BITS;
			x2 = (x * x) >> 30;
			s  = longint'(x);
			t  = ((x * x2) >> 30) / 6;   s = s - longint'(t);
			t  = ((t * x2) >> 30) / 20;  s = s + longint'(t);
			t  = ((t * x2) >> 30) / 42;  s = s - longint'(t);
			t  = ((t * x2) >> 30) / 72;  s = s + longint'(t);
			t  = ((t * x2) >> 30) / 110; s = s - longint'(t);
			if (s < 0) s = 0;
			if (s > longint'(swgt_pkg::ONE_Q30)) s = longint'(swgt_pkg::ONE_Q30);
			if (neg)
				g = ((swgt_pkg::ONE_Q30 - longint'(s)) * 255) >> 31;
			else
				g = ((longint'(s) + swgt_pkg::ONE_Q30) * 255) >> 31;
			lut[r*GW +: GW] = g[GW-1:0];
		end
		return lut;
	endfunction

	localparam logic [LUT_N*GW-1:0] POS_LUT = build_lut(1'b0);
	localparam logic [LUT_N*GW-1:0] NEG_LUT = build_lut(1'b1);

	logic                   v_s5, v_s6;
	logic                   rdy_s5, rdy_s6;
	logic [IW-1:0]          idx_s5;
	logic                   neg_s5;
	logic [IW-1:0]          r_ext;
	swgt_pkg::gray_t        gray_s6;

	assign rdy_s6   = !v_s6 || out_ready;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign in_ready = rdy_s5;

	assign r_ext = {1'b0, addr[PHASE_BITS-3:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s5) v_s5 <= in_valid;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && in_valid) begin
			// odd quadrants run backwards from the peak
			idx_s5 <= addr[PHASE_BITS-2] ? QUARTER_I - r_ext : r_ext;
			neg_s5 <= addr[PHASE_BITS-1];
		end
		if (rdy_s6 && v_s5)
			gray_s6 <= neg_s5 ? NEG_LUT[idx_s5*GW +: GW] : POS_LUT[idx_s5*GW +: GW];
	end

	assign out_valid = v_s6;
	assign gray      = gray_s6;

endmodule

// File: design/swgt_checker.sv
// Port-level checker for the sine wave gray texel generator, bound to the top.
module swgt_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [swgt_pkg::APB_AW-1:0]     paddr,
	input  logic [swgt_pkg::APB_DW-1:0]     pwdata,
	input  logic [swgt_pkg::APB_DW-1:0]     prdata,
	input  logic                            pready,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  swgt_pkg::coord_t                x_coord,
	input  swgt_pkg::coord_t                y_coord,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  swgt_pkg::gray_t                 gray
);

	// a stalled gray word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gray))
		else $error("gray word changed or dropped while stalled");

	// an open output drains the whole pipe, so the input side must be open too
	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output is ready");

	// nothing comes out right after reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("gray word valid right after reset");

	// phase offset reads back what was written
	a_offset_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[3:2] == swgt_pkg::REG_PHASE_OFFSET
		##1 paddr[3:2] == swgt_pkg::REG_PHASE_OFFSET
		|-> prdata[swgt_pkg::OFFS_W-1:0] == $past(pwdata[swgt_pkg::OFFS_W-1:0]))
		else $error("phase offset read-back mismatch");

	// spatial frequency reads back what was written
	a_freq_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[3:2] == swgt_pkg::REG_SPATIAL_FREQ
		##1 paddr[3:2] == swgt_pkg::REG_SPATIAL_FREQ
		|-> prdata[swgt_pkg::FREQ_W-1:0] == $past(pwdata[swgt_pkg::FREQ_W-1:0]))
		else $error("spatial frequency read-back mismatch");

endmodule

bind sine_wave_gray_texel swgt_checker u_swgt_checker (.*);

// File: tb/sv/swgt_gray_checker.sv
// Checker for the sine wave gray texel: tracks registers, predicts gray words, compares.
module swgt_gray_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [swgt_pkg::APB_AW-1:0] paddr,
	input  logic [swgt_pkg::APB_DW-1:0] pwdata,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  swgt_pkg::coord_t            x_coord,
	input  swgt_pkg::coord_t            y_coord,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  swgt_pkg::gray_t             gray,
	output int                          fails,
	output int                          waiting,
	output int                          checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int              PB       = 12;
	localparam int              PHASE_FR = 38;
	localparam int              QUARTER  = 1 << (PB - 2);
	localparam longint unsigned Q30_ONE  = 64'd1 << 30;
	localparam longint unsigned Q30_2PI  = 64'd6746518852;
	localparam longint unsigned PH_MASK  = (64'd1 << PHASE_FR) - 64'd1;

	typedef struct {
		swgt_pkg::coord_t x;
		swgt_pkg::coord_t y;
		swgt_pkg::gray_t  g;
	} gray_due_t;

	swgt_pkg::dir_t  wave_dx, wave_dy;
	swgt_pkg::freq_t wave_freq;
	swgt_pkg::offs_t wave_offs;

	gray_due_t gray_due[$];
	gray_due_t head;
	int        fail_count = 0;
	int        checked_n  = 0;

	// Taylor series up to x^11 on a first-quadrant angle in Q30 radians
	function automatic longint quarter_sine(longint unsigned ang);
		longint unsigned sq, term;
		longint          acc;
		int              n;
		sq  = (ang * ang) >> 30;
		term = ang;
		acc  = longint'(ang);
		for (n = 1; n <= 5; n++) begin
			term = ((term * sq) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		if (acc > longint'(Q30_ONE))
			acc = longint'(Q30_ONE);
		return acc;
	endfunction

	function automatic longint turn_sine(logic [PB-1:0] addr);
		logic [1:0]      quad;
		longint unsigned r;
		longint          s;
		quad = addr[PB-1 -: 2];
		r    = 64'(addr[PB-3:0]);
		if (quad[0])
			r = QUARTER - r;
		s = quarter_sine((r * Q30_2PI) >> PB);
		return quad[1] ? -s : s;
	endfunction

	function automatic swgt_pkg::gray_t predict_gray(swgt_pkg::coord_t x, swgt_pkg::coord_t y);
		longint          dot;
		longint unsigned ph, g;
		logic [PB-1:0]   addr;
		dot  = longint'(wave_dx) * longint'(x) + longint'(wave_dy) * longint'(y);
		ph   = $unsigned(dot) * 64'(wave_freq) + (64'(wave_offs) << 22);
		ph   = ph & PH_MASK;
		addr = ph[PHASE_FR-1 -: PB];
		g    = ($unsigned(turn_sine(addr) + longint'(Q30_ONE)) * 64'd255) >> 31;
		if (g > 64'd255)
			g = 64'd255;
		return g[7:0];
	endfunction

	task automatic report(input string what);
		fail_count++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// register copy, written only through the APB port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_dx   <= '0;
			wave_dy   <= '0;
			wave_freq <= '0;
			wave_offs <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (swgt_pkg::reg_idx_t'(paddr[swgt_pkg::APB_AW-1:2]))
				swgt_pkg::REG_DIR_X:        wave_dx   <= pwdata[swgt_pkg::DIR_W-1:0];
				swgt_pkg::REG_DIR_Y:        wave_dy   <= pwdata[swgt_pkg::DIR_W-1:0];
				swgt_pkg::REG_SPATIAL_FREQ: wave_freq <= pwdata[swgt_pkg::FREQ_W-1:0];
				swgt_pkg::REG_PHASE_OFFSET: wave_offs <= pwdata[swgt_pkg::OFFS_W-1:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_due.delete();
			fails   <= fail_count;
			waiting <= 0;
			checked <= checked_n;
		end else begin
			if (in_valid && in_ready)
				gray_due.push_back('{x_coord, y_coord, predict_gray(x_coord, y_coord)});
			if (out_valid && out_ready) begin
				if (gray_due.size() == 0) begin
					report($sformatf("gray %0d arrived with nothing pending", gray));
				end else begin
					head = gray_due.pop_front();
					checked_n++;
					if (gray !== head.g)
						report($sformatf("pixel (%0d,%0d) gray %0d, want %0d",
							head.x, head.y, gray, head.g));
				end
			end
			fails   <= fail_count;
			waiting <= gray_due.size();
			checked <= checked_n;
		end
	end

endmodule

// File: tb/sv/tb_sine_wave_gray_texel.sv
// Testbench top for the sine wave gray texel: stimulus, register setup and verdict.
module tb_sine_wave_gray_texel;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LAT  = 6;      // stages between input and output word
	localparam int DRAIN_MAX = 50000;  // cycles allowed for outstanding words to come
	localparam int PER_SET   = 108;    // random pixel words per register setting

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        psel      = 1'b0;
	logic                        penable   = 1'b0;
	logic                        pwrite    = 1'b0;
	logic [swgt_pkg::APB_AW-1:0] paddr     = '0;
	logic [swgt_pkg::APB_DW-1:0] pwdata    = '0;
	logic [swgt_pkg::APB_DW-1:0] prdata;
	logic                        pready;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	swgt_pkg::coord_t            x_coord   = '0;
	swgt_pkg::coord_t            y_coord   = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	swgt_pkg::gray_t             gray;

	int fails, waiting, checked;

	// idling knobs: percent of cycles the sender holds off / the receiver stalls.
	// calm suspends both for a stretch of words.
	int idle_pct  = 0;
	int stall_pct = 0;
	bit calm      = 1'b0;

	int sent     = 0;
	int settings = 0;
	int mode, s, i;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	sine_wave_gray_texel uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.gray      (gray)
	);

	swgt_gray_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.gray      (gray),
		.fails     (fails),
		.waiting   (waiting),
		.checked   (checked)
	);

	// Receiver: a fresh ready decision every clock.
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= stall_pct);
	end

	// One APB write: setup, access until pready, then idle, so that the
	// next transfer starts in a fresh time step.
	task automatic apb_write(input swgt_pkg::reg_idx_t idx,
			input logic [swgt_pkg::APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Sender pause: hold valid low until every predicted gray word is out,
	// then let the pipeline settle. The checker's count is registered, so the
	// first look happens only once the count has been updated.
	task automatic drain_pixels();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
			guard++;
		end while (waiting != 0 && guard < DRAIN_MAX);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	// New wave setting; only done with the pipeline empty.
	task automatic set_wave(input swgt_pkg::dir_t dx, input swgt_pkg::dir_t dy,
			input swgt_pkg::freq_t f, input swgt_pkg::offs_t o);
		drain_pixels();
		apb_write(swgt_pkg::REG_DIR_X,        32'(dx));
		apb_write(swgt_pkg::REG_DIR_Y,        32'(dy));
		apb_write(swgt_pkg::REG_SPATIAL_FREQ, 32'(f));
		apb_write(swgt_pkg::REG_PHASE_OFFSET, 32'(o));
		settings++;
	endtask

	// Offer one pixel word; returns right after the edge that accepted it,
	// with valid still high so back-to-back words need no bubble.
	task automatic send_pixel(input swgt_pkg::coord_t x, input swgt_pkg::coord_t y);
		while (!calm && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		x_coord  <= x;
		y_coord  <= y;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// Random pickers lean on the extremes of each register.
	function automatic swgt_pkg::dir_t pick_dir();
		case ($urandom_range(4))
			0:       return 16'sh8000;
			1:       return 16'sh7FFF;
			2:       return 16'sh4000;    // unit length
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic swgt_pkg::freq_t pick_freq();
		case ($urandom_range(4))
			0:       return '0;
			1:       return 24'hFFFFFF;
			2:       return 24'($urandom_range(65535));  // slow, smooth wave
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic swgt_pkg::offs_t pick_offs();
		case ($urandom_range(3))
			0:       return '0;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly legal one-based coordinates; some zero or beyond the image,
	// which the block takes at face value.
	function automatic swgt_pkg::coord_t pick_coord();
		if ($urandom_range(7) == 0)
			return 13'($urandom);
		return 13'($urandom_range(4096, 1));
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. With zero direction the phase is the offset alone:
		// a quarter turn peaks at white, three quarters bottoms at black,
		// zero sits at mid gray.
		set_wave(16'sh0000, 16'sh0000, 24'h000000, 16'h4000);
		send_pixel(13'd1, 13'd1);
		set_wave(16'sh0000, 16'sh0000, 24'h000000, 16'hC000);
		send_pixel(13'd4096, 13'd4096);
		set_wave(16'sh0000, 16'sh0000, 24'h000000, 16'h0000);
		send_pixel(13'd1, 13'd4096);

		// All registers at their extremes, coordinates at the field limits
		// including zero and the out-of-range top.
		set_wave(16'sh7FFF, 16'sh8000, 24'hFFFFFF, 16'hFFFF);
		send_pixel(13'd0,    13'd0);
		send_pixel(13'd1,    13'd1);
		send_pixel(13'd4096, 13'd4096);
		send_pixel(13'd8191, 13'd8191);
		send_pixel(13'd1,    13'd4096);
		send_pixel(13'd4096, 13'd1);
		send_pixel(13'd8191, 13'd0);
		send_pixel(13'd0,    13'd8191);
		send_pixel(13'd4097, 13'd4097);

		// Diagonal wave with a negative y component, short sweep along x and y.
		set_wave(16'sh4000, 16'shC000, 24'h000100, 16'h0000);
		send_pixel(13'd1,  13'd1);
		send_pixel(13'd2,  13'd1);
		send_pixel(13'd3,  13'd5);
		send_pixel(13'd64, 13'd1);
		send_pixel(13'd1,  13'd64);

		// Random part: three idling profiles, four register settings each.
		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					idle_pct  = 16;
					stall_pct = 72;
				end
				1: begin
					idle_pct  = 72;
					stall_pct = 16;
				end
				default: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
			endcase
			for (s = 0; s < 4; s++) begin
				set_wave(pick_dir(), pick_dir(), pick_freq(), pick_offs());
				for (i = 0; i < PER_SET; i++) begin
					// roughly one stretch in four runs with no idling at all
					if (i % 36 == 0)
						calm = ($urandom_range(3) == 0);
					// sender holds off until the pipeline has emptied
					if (i == PER_SET / 2)
						drain_pixels();
					send_pixel(pick_coord(), pick_coord());
				end
			end
		end
		calm = 1'b0;

		drain_pixels();

		$display("Sent %0d pixel words over %0d wave settings, idling 16/72, 72/16 and none.",
			sent, settings);
		$display("Compared %0d gray words, %0d mismatches, %0d still outstanding.",
			checked, fails, waiting);
		if (fails == 0 && waiting == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#(5_000_000);
		$display("Timeout with %0d gray words outstanding.", waiting);
		$display("FAIL");
		$finish;
	end

endmodule
